[rtl/core/dat_pkg.sv]
package dat_pkg;

  localparam int MAC_W    = 48;
  localparam int IP_W     = 32;
  localparam int HANDLE_W = 8;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;

  localparam logic [KIND_W-1:0] KIND_REGISTER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIND_IP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND_MAC = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [MAC_W-1:0]    mac;
    logic [IP_W-1:0]     ip;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] found_handle;
    logic [SLOT_W-1:0]   slot;
    logic                multiple;
  } result_t;

endpackage

[rtl/core/dat_entry_mem.sv]
module dat_entry_mem #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  dat_pkg::entry_t          wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output dat_pkg::entry_t          rd_data
);
  import dat_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/dat_ctrl.sv]
module dat_ctrl #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [dat_pkg::IP_W-1:0]     default_ip,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [dat_pkg::KIND_W-1:0]   kind,
  input  logic [dat_pkg::MAC_W-1:0]    mac,
  input  logic [dat_pkg::IP_W-1:0]     ip,
  input  logic [dat_pkg::HANDLE_W-1:0] handle,
  output logic                         res_valid,
  input  logic                         res_ready,
  output dat_pkg::result_t             res
);
  import dat_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_TAIL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;

  logic [KIND_W-1:0]   req_kind;
  logic [MAC_W-1:0]    req_mac;
  logic [IP_W-1:0]     req_ip;
  logic [HANDLE_W-1:0] req_handle;
  logic                req_bad;

  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_valid;

  logic                hit_any;
  logic                hit_multi;
  logic [IDX_W-1:0]    hit_idx;
  logic [HANDLE_W-1:0] hit_handle;

  logic used [TABLE_ENTRIES];

  logic             rd_en;
  entry_t           rd_data;
  logic             wr_en;
  entry_t           wr_data;
  logic             free_any;
  logic [IDX_W-1:0] free_idx;
  logic             match;
  logic             accept;
  logic             take;

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign rd_en     = (state == S_SCAN);
  assign res_valid = (state == S_DONE);
  assign take      = res_valid && res_ready;

  dat_entry_mem #(.DEPTH(TABLE_ENTRIES)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
      if (!used[k]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(k);
      end
    end
  end

  always_comb begin
    if (req_kind == KIND_FIND_IP) begin
      match = used[cmp_idx] && (rd_data.ip == req_ip);
    end else begin
      match = used[cmp_idx] && (rd_data.mac == req_mac);
    end
  end

  always_comb begin
    res = '{status: ST_INVALID, found_handle: '0, slot: '0, multiple: 1'b0};
    if (!req_bad) begin
      if (req_kind == KIND_REGISTER) begin
        if (hit_any) begin
          res.status = ST_EXISTS;
        end else if (!free_any) begin
          res.status = ST_FULL;
        end else begin
          res.status = ST_OK;
          res.slot   = to_slot(free_idx);
        end
      end else if (hit_any) begin
        res.status       = ST_OK;
        res.found_handle = hit_handle;
        res.slot         = to_slot(hit_idx);
        res.multiple     = hit_multi;
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end
  end

  assign wr_en = take && !req_bad && (req_kind == KIND_REGISTER) && !hit_any && free_any;
  assign wr_data = '{mac: req_mac, ip: default_ip, handle: req_handle};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cmp_valid <= 1'b0;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        used[k] <= 1'b0;
      end
    end else begin
      cmp_valid <= rd_en;
      if (wr_en) begin
        used[free_idx] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (kind == KIND_FIND_IP || kind == KIND_FIND_MAC ||
                      (kind == KIND_REGISTER && default_ip != '0 && ip == '0))
                     ? S_SCAN : S_DONE;
          end
        end
        S_SCAN: begin
          if (rd_idx == LAST_IDX) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind   <= kind;
      req_mac    <= mac;
      req_ip     <= ip;
      req_handle <= handle;
      req_bad    <= !(kind == KIND_FIND_IP || kind == KIND_FIND_MAC ||
                      (kind == KIND_REGISTER && default_ip != '0 && ip == '0));
      rd_idx     <= '0;
      hit_any    <= 1'b0;
      hit_multi  <= 1'b0;
      hit_idx    <= '0;
      hit_handle <= '0;
    end else begin
      if (rd_en) begin
        rd_idx <= rd_idx + 1'b1;
      end
      cmp_idx <= rd_idx;
      if (cmp_valid && match) begin
        hit_any <= 1'b1;
        if (req_kind == KIND_FIND_IP) begin
          hit_multi  <= hit_any;
          hit_idx    <= cmp_idx;
          hit_handle <= rd_data.handle;
        end else if (!hit_any) begin
          hit_idx    <= cmp_idx;
          hit_handle <= rd_data.handle;
        end
      end
    end
  end

endmodule

[rtl/core/device_address_table_core.sv]
// Each lookup or well-formed register request scans every table entry before its
// result is given; a malformed request goes straight to its result.
// One request is taken at a time; the scan reads one table entry per cycle
// through the single read port of the entry memory.
// Reset: rst is synchronous; it clears all used bits, default_ip and out_valid.
module device_address_table_core #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dat_pkg::IP_W-1:0]         cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [dat_pkg::KIND_W-1:0]       kind,
  input  logic [dat_pkg::MAC_W-1:0]        mac,
  input  logic [dat_pkg::IP_W-1:0]         ip,
  input  logic [dat_pkg::HANDLE_W-1:0]     handle,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dat_pkg::STATUS_W-1:0]     status,
  output logic [dat_pkg::HANDLE_W-1:0]     found_handle,
  output logic [dat_pkg::SLOT_W-1:0]       slot,
  output logic                             multiple
);
  import dat_pkg::*;

  logic [IP_W-1:0] default_ip;
  logic            res_valid;
  logic            res_ready;
  result_t         res;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_ip <= '0;
    end else if (cfg_valid && cfg_ready) begin
      default_ip <= cfg_data;
    end
  end

  dat_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .default_ip (default_ip),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .mac        (mac),
    .ip         (ip),
    .handle     (handle),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status       <= res.status;
      found_handle <= res.found_handle;
      slot         <= res.slot;
      multiple     <= res.multiple;
    end
  end

endmodule

[tb/testbench.sv]
module testbench;
  import dat_pkg::*;

  localparam int TABLE_ENTRIES = 16;
  localparam int SETTLE_CYCLES = TABLE_ENTRIES + 8;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 250;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [MAC_W-1:0] MAC_ONES = {MAC_W{1'b1}};
  localparam logic [IP_W-1:0] IP_ONES = {IP_W{1'b1}};

  typedef struct {
    bit                  set_cfg;
    logic [IP_W-1:0]     cfg_val;
    logic [KIND_W-1:0]   kind;
    logic [MAC_W-1:0]    mac;
    logic [IP_W-1:0]     ip;
    logic [HANDLE_W-1:0] handle;
    bit                  typed;
    result_t             answer;
  } stim_row_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IP_W-1:0]     cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   kind = '0;
  logic [MAC_W-1:0]    mac = '0;
  logic [IP_W-1:0]     ip = '0;
  logic [HANDLE_W-1:0] handle = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] found_handle;
  logic [SLOT_W-1:0]   slot;
  logic                multiple;

  // device table as the block should hold it
  logic [IP_W-1:0]     cur_default_ip = '0;
  bit                  ent_used [TABLE_ENTRIES];
  logic [MAC_W-1:0]    ent_mac [TABLE_ENTRIES];
  logic [IP_W-1:0]     ent_ip [TABLE_ENTRIES];
  logic [HANDLE_W-1:0] ent_handle [TABLE_ENTRIES];

  result_t             pending_answers [$];
  stim_row_t           directed_rows [$];
  logic [MAC_W-1:0]    mac_pool [$];
  logic [IP_W-1:0]     ip_pool [$];
  int                  errors = 0;
  int                  quiet = 0;
  bit                  pressure_go = 1'b0;
  bit                  pressure_done = 1'b0;

  device_address_table_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .mac(mac),
    .ip(ip),
    .handle(handle),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .found_handle(found_handle),
    .slot(slot),
    .multiple(multiple)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic result_t table_answer(input logic [KIND_W-1:0] k,
                                           input logic [MAC_W-1:0] m,
                                           input logic [IP_W-1:0] i,
                                           input logic [HANDLE_W-1:0] h);
    result_t r;
    int hits;
    int last_hit;
    bit done;
    r = '0;
    hits = 0;
    last_hit = 0;
    done = 1'b0;
    case (k)
      KIND_REGISTER: begin
        if (cur_default_ip == '0 || i != '0) begin
          r.status = ST_INVALID;
        end else begin
          for (int s = 0; s < TABLE_ENTRIES; s++)
            if (ent_used[s] && ent_mac[s] == m) done = 1'b1;
          if (done) begin
            r.status = ST_EXISTS;
          end else begin
            r.status = ST_FULL;
            for (int s = 0; s < TABLE_ENTRIES; s++) begin
              if (!done && !ent_used[s]) begin
                ent_used[s] = 1'b1;
                ent_mac[s] = m;
                ent_ip[s] = cur_default_ip;
                ent_handle[s] = h;
                r.status = ST_OK;
                r.slot = s[SLOT_W-1:0];
                done = 1'b1;
              end
            end
          end
        end
      end
      KIND_FIND_IP: begin
        for (int s = 0; s < TABLE_ENTRIES; s++) begin
          if (ent_used[s] && ent_ip[s] == i) begin
            hits++;
            last_hit = s;
          end
        end
        if (hits == 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.status = ST_OK;
          r.found_handle = ent_handle[last_hit];
          r.slot = last_hit[SLOT_W-1:0];
          r.multiple = (hits > 1);
        end
      end
      KIND_FIND_MAC: begin
        r.status = ST_NOT_FOUND;
        for (int s = 0; s < TABLE_ENTRIES; s++) begin
          if (!done && ent_used[s] && ent_mac[s] == m) begin
            r.status = ST_OK;
            r.found_handle = ent_handle[s];
            r.slot = s[SLOT_W-1:0];
            done = 1'b1;
          end
        end
      end
      default: r.status = ST_INVALID;
    endcase
    return r;
  endfunction

  task automatic sender_pause(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_request(input logic [KIND_W-1:0] k, input logic [MAC_W-1:0] m,
                              input logic [IP_W-1:0] i, input logic [HANDLE_W-1:0] h,
                              input bit typed, input result_t typed_answer);
    result_t predicted;
    @(negedge clk);
    in_valid <= 1'b1;
    kind <= k;
    mac <= m;
    ip <= i;
    handle <= h;
    do @(posedge clk); while (in_stall);
    predicted = table_answer(k, m, i, h);
    pending_answers.push_back(typed ? typed_answer : predicted);
    if (k == KIND_REGISTER) mac_pool.push_back(m);
  endtask

  // block must be idle before the default IP changes
  task automatic write_default_ip(input logic [IP_W-1:0] v);
    sender_pause(1);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cur_default_ip = v;
    ip_pool.push_back(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input bit set_cfg, input logic [IP_W-1:0] cfg_val,
                         input logic [KIND_W-1:0] k, input logic [MAC_W-1:0] m,
                         input logic [IP_W-1:0] i, input logic [HANDLE_W-1:0] h,
                         input bit typed, input result_t answer);
    stim_row_t row;
    row.set_cfg = set_cfg;
    row.cfg_val = cfg_val;
    row.kind = k;
    row.mac = m;
    row.ip = i;
    row.handle = h;
    row.typed = typed;
    row.answer = answer;
    directed_rows.push_back(row);
  endtask

  function automatic logic [MAC_W-1:0] any_mac();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[MAC_W-1:0];
  endfunction

  task automatic send_random_request();
    logic [KIND_W-1:0]   k;
    logic [MAC_W-1:0]    m;
    logic [IP_W-1:0]     i;
    logic [HANDLE_W-1:0] h;
    int                  r;
    r = $urandom_range(0, 99);
    k = KIND_REGISTER;
    m = any_mac();
    i = '0;
    h = HANDLE_W'($urandom_range(0, 255));
    if (r < 3) begin
      k = KIND_REGISTER;
    end else if (r < 10) begin
      m = mac_pool[$urandom_range(0, mac_pool.size() - 1)];
    end else if (r < 14) begin
      i = $urandom;
    end else if (r < 45) begin
      k = KIND_FIND_IP;
      i = ($urandom_range(0, 3) != 0) ? ip_pool[$urandom_range(0, ip_pool.size() - 1)]
                                       : $urandom;
    end else if (r < 85) begin
      k = KIND_FIND_MAC;
      if ($urandom_range(0, 3) != 0) m = mac_pool[$urandom_range(0, mac_pool.size() - 1)];
      i = $urandom;
    end else if (r < 91) begin
      k = KIND_UNUSED;
      i = $urandom;
    end else begin
      k = KIND_W'($urandom_range(0, 3));
      i = $urandom;
    end
    send_request(k, m, i, h, 1'b0, '0);
  endtask

  initial begin : stimulus
    logic [IP_W-1:0] v;
    int              count;
    int              burst;
    add_row(0, '0, KIND_REGISTER, '0, '0, 8'h00, 1, '{ST_INVALID, 8'h00, 4'd0, 1'b0});
    add_row(0, '0, KIND_FIND_IP, '0, '0, 8'h00, 1, '{ST_NOT_FOUND, 8'h00, 4'd0, 1'b0});
    add_row(0, '0, KIND_FIND_MAC, MAC_ONES, '0, 8'h00, 1,
            '{ST_NOT_FOUND, 8'h00, 4'd0, 1'b0});
    add_row(0, '0, KIND_UNUSED, MAC_ONES, IP_ONES, 8'hFF, 1,
            '{ST_INVALID, 8'h00, 4'd0, 1'b0});
    add_row(1, IP_ONES, KIND_REGISTER, MAC_ONES, '0, 8'hFF, 1,
            '{ST_OK, 8'h00, 4'd0, 1'b0});
    add_row(0, '0, KIND_REGISTER, '0, '0, 8'h00, 1, '{ST_OK, 8'h00, 4'd1, 1'b0});
    add_row(0, '0, KIND_REGISTER, MAC_ONES, '0, 8'h12, 1, '{ST_EXISTS, 8'h00, 4'd0, 1'b0});
    add_row(0, '0, KIND_REGISTER, 48'h1, IP_ONES, 8'h34, 1,
            '{ST_INVALID, 8'h00, 4'd0, 1'b0});
    add_row(0, '0, KIND_FIND_IP, '0, IP_ONES, 8'h00, 1, '{ST_OK, 8'h00, 4'd1, 1'b1});
    add_row(0, '0, KIND_FIND_MAC, MAC_ONES, '0, 8'h00, 1, '{ST_OK, 8'hFF, 4'd0, 1'b0});
    add_row(0, '0, KIND_FIND_MAC, '0, '0, 8'h00, 1, '{ST_OK, 8'h00, 4'd1, 1'b0});
    add_row(0, '0, KIND_FIND_IP, '0, '0, 8'h00, 1, '{ST_NOT_FOUND, 8'h00, 4'd0, 1'b0});
    add_row(1, 32'h1, KIND_REGISTER, 48'h1, '0, 8'h5A, 1, '{ST_OK, 8'h00, 4'd2, 1'b0});
    add_row(0, '0, KIND_FIND_IP, '0, 32'h1, 8'h00, 1, '{ST_OK, 8'h5A, 4'd2, 1'b0});
    add_row(0, '0, KIND_REGISTER, 48'hA5A5_A5A5_A5A5, '0, 8'h81, 1,
            '{ST_OK, 8'h00, 4'd3, 1'b0});
    add_row(0, '0, KIND_FIND_IP, '0, 32'h1, 8'h00, 1, '{ST_OK, 8'h81, 4'd3, 1'b1});
    add_row(0, '0, KIND_UNUSED, '0, '0, 8'h00, 1, '{ST_INVALID, 8'h00, 4'd0, 1'b0});
    add_row(0, '0, KIND_FIND_MAC, 48'h5A5A_5A5A_5A5A, '0, 8'h00, 0, '0);
    add_row(0, '0, KIND_REGISTER, 48'h2, '0, 8'h7E, 0, '0);
    add_row(0, '0, KIND_FIND_MAC, 48'h2, 32'hDEAD_BEEF, 8'h00, 0, '0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[n]) begin
      if (directed_rows[n].set_cfg) write_default_ip(directed_rows[n].cfg_val);
      send_request(directed_rows[n].kind, directed_rows[n].mac, directed_rows[n].ip,
                   directed_rows[n].handle, directed_rows[n].typed,
                   directed_rows[n].answer);
      sender_pause($urandom_range(0, 2));
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: v = $urandom;
        1: v = IP_ONES;
        2: v = '0;
        3: v = ip_pool[$urandom_range(0, ip_pool.size() - 1)];
        4: v = 32'h1;
        default: v = $urandom;
      endcase
      write_default_ip(v);
      if (phase == 1) pressure_go = 1'b1;
      count = 0;
      while (count < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        for (int b = 0; b < burst && count < PHASE_ITEMS; b++) begin
          send_random_request();
          count++;
        end
        if ($urandom_range(0, 2) != 0) sender_pause($urandom_range(1, 8));
      end
    end

    sender_pause(1);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // output back-pressure; one long hold-off fills the block
  initial begin : receiver
    int mode;
    int seg;
    forever begin
      if (pressure_go && !pressure_done) begin
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        pressure_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        seg = $urandom_range(16, 128);
        for (int n = 0; n < seg; n++) begin
          @(negedge clk);
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            2: out_stall <= n[0];
            default: out_stall <= (n[1:0] != 2'd3);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{status, found_handle, slot, multiple};
      if (pending_answers.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status=%0d handle=%0h slot=%0d multiple=%0b",
                   got.status, got.found_handle, got.slot, got.multiple);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %0d/%0h/%0d/%0b got %0d/%0h/%0d/%0b",
                     want.status, want.found_handle, want.slot, want.multiple,
                     got.status, got.found_handle, got.slot, got.multiple);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
